>>> design/bilinear_image_resize_top_defines.svh
// Assertion macros shared by the resize design.
// Both macros sample on aclk and are disabled while aresetn is low.
`ifndef BILINEAR_IMAGE_RESIZE_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_RESIZE_TOP_DEFINES_SVH

`define BIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define BIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bir_pkg.sv
`timescale 1ns / 1ps

package bir_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COORD_W     = 12;
    localparam int IDX_W       = 12;
    localparam int WEIGHT_W    = 17;
    localparam int CP_W        = SAMPLE_BITS + 16;
    localparam int TOTAL_W     = SAMPLE_BITS + 32;

    localparam logic [WEIGHT_W-1:0] Q_ONE = WEIGHT_W'(65536);

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef struct packed {
        logic                          opcode;
        logic [COORD_W-1:0]            row;
        logic [COORD_W-1:0]            col;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_value;
        logic [COORD_W-1:0]            out_row;
        logic [COORD_W-1:0]            out_col;
    } out_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]    lo;
        logic [IDX_W-1:0]    hi;
        logic [WEIGHT_W-1:0] w_lo;
        logic [WEIGHT_W-1:0] w_hi;
    } axis_map_t;

endpackage

>>> design/bir_axis.sv
`timescale 1ns / 1ps

module bir_axis (
    input  logic                      aclk,
    input  logic                      load_coord,
    input  logic                      load_map,
    input  logic [bir_pkg::COORD_W-1:0] coord,
    input  logic [12:0]               target,
    input  logic [19:0]               step,
    input  logic [bir_pkg::IDX_W-1:0] src_last,
    output bir_pkg::axis_map_t        map
);
    import bir_pkg::*;

    localparam int PROD_W = 33;

    logic [PROD_W-1:0] prod_reg;
    logic              scaled_reg;
    axis_map_t         map_reg;
    axis_map_t         map_next;

    logic [PROD_W-1:0] diff;
    logic              negative;
    logic [15:0]       idx_full;
    logic [IDX_W-1:0]  lo;

    always_ff @(posedge aclk) begin
        if (load_coord) begin
            prod_reg   <= {{(PROD_W - COORD_W - 1){1'b0}}, coord, 1'b1}
                          * {{(PROD_W - 20){1'b0}}, step};
            scaled_reg <= (target > 13'd1);
        end
        if (load_map) begin
            map_reg <= map_next;
        end
    end

    always_comb begin
        negative = scaled_reg && (prod_reg < PROD_W'(Q_ONE));
        if (scaled_reg && !negative) begin
            diff = prod_reg - PROD_W'(Q_ONE);
        end else begin
            diff = '0;
        end
        idx_full = diff[32:17];
        if (idx_full > 16'(src_last)) begin
            lo = src_last;
        end else begin
            lo = idx_full[IDX_W-1:0];
        end
        if (negative) begin
            map_next.lo   = '0;
            map_next.hi   = '0;
            map_next.w_lo = Q_ONE;
            map_next.w_hi = '0;
        end else begin
            map_next.lo   = lo;
            map_next.hi   = (lo < src_last) ? lo + IDX_W'(1) : lo;
            map_next.w_hi = {1'b0, diff[16:1]};
            map_next.w_lo = Q_ONE - {1'b0, diff[16:1]};
        end
    end

    assign map = map_reg;

endmodule

>>> design/bilinear_image_resize_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    in_item_t: opcode, row, col, sample
// m_        out        m_valid / m_ready    out_item_t: out_value, out_row, out_col
// APB       in         psel, penable, ...   six geometry and step registers
//
// A write request stores its sample in the single-port store when in range.
// A compute request passes from acceptance to a loaded result register through
// a mapping step, four store reads, the multiply and sum stages and the load.
// s_ready returns once the result is loaded; no new request is taken before then.
// The result register lets the next request be accepted while a result waits.
// Reset clears the control state and loads the register defaults; the store
// contents are undefined until written.

`include "bilinear_image_resize_top_defines.svh"

module bilinear_image_resize_top #(
    parameter int MAX_SRC_H = 256,
    parameter int MAX_SRC_W = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bir_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bir_pkg::out_item_t  m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bir_pkg::*;

    localparam int RAW   = $clog2(MAX_SRC_H);
    localparam int CAW   = $clog2(MAX_SRC_W);
    localparam int DEPTH = 1 << (RAW + CAW);

    localparam logic [2:0] REG_SRC_H  = 3'd0;
    localparam logic [2:0] REG_SRC_W  = 3'd1;
    localparam logic [2:0] REG_TGT_H  = 3'd2;
    localparam logic [2:0] REG_TGT_W  = 3'd3;
    localparam logic [2:0] REG_ROW_ST = 3'd4;
    localparam logic [2:0] REG_COL_ST = 3'd5;

    localparam logic [TOTAL_W-1:0] ROUND_HALF = TOTAL_W'(64'h8000_0000);
    localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_READ,
        ST_DRAIN,
        ST_OUT
    } state_t;

    function automatic logic [IDX_W-1:0] size_last(input logic [8:0] v,
                                                   input logic [12:0] maxv);
        logic [12:0] ext;
        ext = {4'b0, v};
        if (v == 9'd0) begin
            return '0;
        end else if (ext > maxv) begin
            return IDX_W'(maxv - 13'd1);
        end else begin
            return IDX_W'(ext - 13'd1);
        end
    endfunction

    logic [8:0]  source_height_reg;
    logic [8:0]  source_width_reg;
    logic [12:0] target_height_reg;
    logic [12:0] target_width_reg;
    logic [19:0] row_step_reg;
    logic [19:0] col_step_reg;

    state_t     state_reg;
    logic [1:0] cnt_reg;
    in_item_t   item_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    logic [SAMPLE_BITS-1:0] store_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic                   accept;
    logic                   start_compute;
    logic                   cfg_write;
    logic                   mem_we;
    logic                   rd_en;
    logic [RAW+CAW-1:0]     wr_addr;
    logic [RAW+CAW-1:0]     rd_addr;
    logic [RAW+CAW-1:0]     mem_addr;
    logic [IDX_W-1:0]       row_last;
    logic [IDX_W-1:0]       col_last;
    axis_map_t              row_map;
    axis_map_t              col_map;
    logic [IDX_W-1:0]       rd_row;
    logic [IDX_W-1:0]       rd_col;

    logic                   rd_pend_reg;
    logic [1:0]             rd_sel_reg;
    logic                   cp_valid_reg;
    logic [1:0]             cp_sel_reg;
    logic [CP_W-1:0]        colprod_reg;
    logic [CP_W-1:0]        rsum_reg;
    logic                   rv_reg;
    logic                   rin_sel_reg;
    logic [CP_W-1:0]        rowin_reg;
    logic                   rpv_reg;
    logic                   rp_sel_reg;
    logic [TOTAL_W-1:0]     rowprod_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   fin;
    logic                   pair_first;
    logic                   pair_second;
    logic                   pipe_busy;

    logic [SAMPLE_BITS-1:0]          biased;
    logic [WEIGHT_W-1:0]             wcol;
    logic [WEIGHT_W-1:0]             wrow;
    logic [SAMPLE_BITS+WEIGHT_W-1:0] cp_full;
    logic [CP_W+WEIGHT_W-1:0]        rp_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_height_reg <= 9'd1;
            source_width_reg  <= 9'd1;
            target_height_reg <= 13'd1;
            target_width_reg  <= 13'd1;
            row_step_reg      <= 20'd65536;
            col_step_reg      <= 20'd65536;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_SRC_H:  source_height_reg <= pwdata[8:0];
                REG_SRC_W:  source_width_reg  <= pwdata[8:0];
                REG_TGT_H:  target_height_reg <= pwdata[12:0];
                REG_TGT_W:  target_width_reg  <= pwdata[12:0];
                REG_ROW_ST: row_step_reg      <= pwdata[19:0];
                REG_COL_ST: col_step_reg      <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SRC_H:  prdata = {23'd0, source_height_reg};
            REG_SRC_W:  prdata = {23'd0, source_width_reg};
            REG_TGT_H:  prdata = {19'd0, target_height_reg};
            REG_TGT_W:  prdata = {19'd0, target_width_reg};
            REG_ROW_ST: prdata = {12'd0, row_step_reg};
            REG_COL_ST: prdata = {12'd0, col_step_reg};
            default:    prdata = '0;
        endcase
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign start_compute = accept && (s_data.opcode == OP_COMPUTE);
    assign mem_we        = accept && (s_data.opcode == OP_WRITE)
                           && ({1'b0, s_data.row} < 13'(MAX_SRC_H))
                           && ({1'b0, s_data.col} < 13'(MAX_SRC_W));
    assign rd_en         = (state_reg == ST_READ);

    assign row_last = size_last(source_height_reg, 13'(MAX_SRC_H));
    assign col_last = size_last(source_width_reg, 13'(MAX_SRC_W));

    bir_axis u_row_axis (
        .aclk       (aclk),
        .load_coord (start_compute),
        .load_map   (state_reg == ST_MAP),
        .coord      (s_data.row),
        .target     (target_height_reg),
        .step       (row_step_reg),
        .src_last   (row_last),
        .map        (row_map)
    );

    bir_axis u_col_axis (
        .aclk       (aclk),
        .load_coord (start_compute),
        .load_map   (state_reg == ST_MAP),
        .coord      (s_data.col),
        .target     (target_width_reg),
        .step       (col_step_reg),
        .src_last   (col_last),
        .map        (col_map)
    );

    assign rd_row   = cnt_reg[1] ? row_map.hi : row_map.lo;
    assign rd_col   = cnt_reg[0] ? col_map.hi : col_map.lo;
    assign rd_addr  = {rd_row[RAW-1:0], rd_col[CAW-1:0]};
    assign wr_addr  = {s_data.row[RAW-1:0], s_data.col[CAW-1:0]};
    assign mem_addr = rd_en ? rd_addr : wr_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_addr] <= s_data.sample;
        end else if (rd_en) begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    assign biased  = rd_data_reg ^ SIGN_FLIP;
    assign wcol    = rd_sel_reg[0] ? col_map.w_hi : col_map.w_lo;
    assign wrow    = rin_sel_reg ? row_map.w_hi : row_map.w_lo;
    assign cp_full = {{WEIGHT_W{1'b0}}, biased} * {{SAMPLE_BITS{1'b0}}, wcol};
    assign rp_full = {{WEIGHT_W{1'b0}}, rowin_reg} * {{CP_W{1'b0}}, wrow};
    assign fin     = rpv_reg && rp_sel_reg;

    assign pair_first  = cp_valid_reg && !cp_sel_reg[0];
    assign pair_second = cp_valid_reg && cp_sel_reg[0];
    assign pipe_busy   = rd_pend_reg || cp_valid_reg || rv_reg || rpv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg  <= 1'b0;
            cp_valid_reg <= 1'b0;
            rv_reg       <= 1'b0;
            rpv_reg      <= 1'b0;
        end else begin
            rd_pend_reg  <= rd_en;
            cp_valid_reg <= rd_pend_reg;
            rv_reg       <= cp_valid_reg && cp_sel_reg[0];
            rpv_reg      <= rv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_sel_reg <= cnt_reg;
        end
        if (rd_pend_reg) begin
            colprod_reg <= cp_full[CP_W-1:0];
            cp_sel_reg  <= rd_sel_reg;
        end
        if (cp_valid_reg) begin
            if (!cp_sel_reg[0]) begin
                rsum_reg <= colprod_reg;
            end else begin
                rowin_reg   <= rsum_reg + colprod_reg;
                rin_sel_reg <= cp_sel_reg[1];
            end
        end
        if (rv_reg) begin
            rowprod_reg <= rp_full[TOTAL_W-1:0];
            rp_sel_reg  <= rin_sel_reg;
        end
        if (rpv_reg) begin
            if (rp_sel_reg) begin
                total_reg <= total_reg + rowprod_reg;
            end else begin
                total_reg <= rowprod_reg + ROUND_HALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (start_compute) begin
                        item_reg  <= s_data;
                        state_reg <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    cnt_reg   <= 2'd0;
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (fin) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_data_reg.out_value <= total_reg[TOTAL_W-1:32] ^ SIGN_FLIP;
                        m_data_reg.out_row   <= item_reg.row;
                        m_data_reg.out_col   <= item_reg.col;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BIR_ASSERT_NOW(a_port_exclusive, mem_we, !rd_en, "store write and read in the same cycle")
    `BIR_ASSERT_NOW(a_fin_in_drain, fin, state_reg == ST_DRAIN, "sum finished outside drain")
    `BIR_ASSERT_NEXT(a_drain_to_out, fin, state_reg == ST_OUT, "drain did not end")
    `BIR_ASSERT_NOW(a_pair_order, pair_second, $past(pair_first), "column pair out of order")
    `BIR_ASSERT_NOW(a_accept_empty, accept, !pipe_busy, "request accepted with pipeline busy")

endmodule
